/* rtl/ljpe_pkg.sv */
// Shared types and constants for the Lennard-Jones pair energy accumulator.
// Used by ljpe_alu and lj_pair_energy_accumulator; depends on nothing.
`default_nettype none
package ljpe_pkg;

  localparam int ENERGY_FRAC_BITS = 16;
  localparam int TERM_SHIFT       = 44 - ENERGY_FRAC_BITS;

  localparam logic [63:0] CAPQ     = 64'h3FFF_FFFF_FFFF_FFFF;
  localparam logic [46:0] TERM_MAX = 47'h7FFF_FFFF_FFFF;

  // Combining rule codes: only the geometric code differs, every other code
  // selects the arithmetic mean.
  localparam logic [1:0] RULE_SPARE_LO  = 2'd0;
  localparam logic [1:0] RULE_RESET     = 2'd1;
  localparam logic [1:0] RULE_GEOMETRIC = 2'd2;
  localparam logic [1:0] RULE_SPARE_HI  = 2'd3;

  localparam logic [5:0] MUL_LAST  = 6'd3;
  localparam logic [5:0] DIV_LAST  = 6'd63;
  localparam logic [5:0] SQRT_LAST = 6'd15;

  typedef enum logic [1:0] {
    ALU_MUL  = 2'd0,
    ALU_DIV  = 2'd1,
    ALU_SQRT = 2'd2
  } alu_op_t;

  typedef struct packed {
    logic        start;
    alu_op_t     op;
    logic [63:0] a;
    logic [63:0] b;
  } alu_req_t;

  typedef struct packed {
    logic         done;
    logic [127:0] data;
  } alu_rsp_t;

endpackage
`default_nettype wire

/* rtl/ljpe_alu.sv */
// Shared iterative arithmetic unit: 64x64 multiply (16-bit digit per cycle),
// 64/24 restoring divide and 32-bit integer square root. Uses ljpe_pkg.
`default_nettype none
module ljpe_alu (
  input  logic               clk,
  input  logic               rst,
  input  ljpe_pkg::alu_req_t req,
  output ljpe_pkg::alu_rsp_t rsp
);

  logic                busy;
  logic                done;
  ljpe_pkg::alu_op_t   op;
  logic [5:0]          cnt;
  logic [63:0]         x;
  logic [63:0]         y;
  logic [127:0]        acc;
  logic [24:0]         r;

  logic [63:0]  x_next;
  logic [63:0]  y_next;
  logic [127:0] acc_next;
  logic [24:0]  r_next;
  logic [5:0]   last_cnt;

  logic [79:0]  pp;
  logic [24:0]  div_sh;
  logic         div_ge;
  logic [18:0]  sq_sh;
  logic [18:0]  sq_trial;
  logic         sq_ge;

  always_comb begin
    pp       = x * y[63:48];
    div_sh   = {r[23:0], x[63]};
    div_ge   = div_sh >= {1'b0, y[23:0]};
    sq_sh    = {r[16:0], x[31:30]};
    sq_trial = {1'b0, acc[15:0], 2'b01};
    sq_ge    = sq_sh >= sq_trial;
    x_next   = x;
    y_next   = y;
    acc_next = acc;
    r_next   = r;
    last_cnt = ljpe_pkg::MUL_LAST;
    case (op)
      ljpe_pkg::ALU_MUL: begin
        acc_next = {acc[111:0], 16'b0} + {48'b0, pp};
        y_next   = {y[47:0], 16'b0};
        last_cnt = ljpe_pkg::MUL_LAST;
      end
      ljpe_pkg::ALU_DIV: begin
        r_next   = div_ge ? (div_sh - {1'b0, y[23:0]}) : div_sh;
        x_next   = {x[62:0], div_ge};
        last_cnt = ljpe_pkg::DIV_LAST;
      end
      ljpe_pkg::ALU_SQRT: begin
        r_next   = {6'b0, sq_ge ? (sq_sh - sq_trial) : sq_sh};
        acc_next = {acc[127:16], acc[14:0], sq_ge};
        x_next   = {x[61:0], 2'b00};
        last_cnt = ljpe_pkg::SQRT_LAST;
      end
      default: begin
        last_cnt = ljpe_pkg::MUL_LAST;
      end
    endcase
  end

  // Control: busy flag, step counter, one-cycle done pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == last_cnt) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: load operands on start, advance one step per busy cycle.
  always_ff @(posedge clk) begin
    if (req.start && !busy) begin
      op  <= req.op;
      x   <= req.a;
      y   <= req.b;
      acc <= '0;
      r   <= '0;
    end else if (busy) begin
      x   <= x_next;
      y   <= y_next;
      acc <= acc_next;
      r   <= r_next;
    end
  end

  always_comb begin
    rsp.done = done;
    case (op)
      ljpe_pkg::ALU_DIV:  rsp.data = {64'b0, x};
      ljpe_pkg::ALU_SQRT: rsp.data = {112'b0, acc[15:0]};
      default:            rsp.data = acc;
    endcase
  end

endmodule
`default_nettype wire

/* rtl/lj_pair_energy_accumulator.sv */
// Top level of the Lennard-Jones 12-6 pair energy accumulator: sequencer,
// running sum and stream ports. Uses ljpe_pkg and ljpe_alu.
`default_nettype none
// One atom pair per input transaction. The block combines sigmas (arithmetic
// mean, or geometric mean when the combining rule register is 2), takes the
// geometric mean of the epsilons, forms s = sigma^2 / r2 and the energy
// 2*eps*(s^6 - s^3), and adds it to a running signed Q32.16 sum (subtracts it
// when s_tuser marks an excluded pair). On the pair carrying s_tlast the
// saturated sum and a sticky saturation flag leave on the master side and the
// sum clears. Every operation runs on one shared iterative unit, so s_tready
// is high only while idle. Each unit operation goes through start, steps and
// done. A pair may use the 64-step divide, up to two 16-step square roots and
// up to seven 4-step multiplies: the geometric rule adds one multiply and one
// square root over the arithmetic rule, and a zero epsilon root goes straight
// to the accumulate step. A zero distance skips the divide, and a saturated
// power skips the last multiply. A finished result waits in the output
// register while the next pair is already accepted; a second final pair
// holds in the accumulate step until that register frees up.
module lj_pair_energy_accumulator (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_wdata,    // combining rule
  input  logic        s_tvalid,
  output logic        s_tready,
  // sigma_a[15:0], sigma_b[31:16], epsil_a[47:32], epsil_b[63:48], dist_sq[87:64]
  input  logic [87:0] s_tdata,
  input  logic        s_tuser,      // excluded
  input  logic        s_tlast,      // last
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,      // energy_total[47:0]
  output logic        m_tuser       // saturated
);

  typedef enum logic [11:0] {
    ST_IDLE     = 12'b0000_0000_0001,
    ST_EPS_MUL  = 12'b0000_0000_0010,
    ST_EPS_SQRT = 12'b0000_0000_0100,
    ST_SIG_MUL  = 12'b0000_0000_1000,
    ST_SIG_SQRT = 12'b0000_0001_0000,
    ST_SQ       = 12'b0000_0010_0000,
    ST_DIV      = 12'b0000_0100_0000,
    ST_P1       = 12'b0000_1000_0000,
    ST_P2       = 12'b0001_0000_0000,
    ST_P3       = 12'b0010_0000_0000,
    ST_TERM     = 12'b0100_0000_0000,
    ST_ACC      = 12'b1000_0000_0000
  } state_t;

  state_t state;
  logic   pending;
  logic [1:0] rule;

  // latched pair
  logic [15:0] sa, sb, ea, eb;
  logic [23:0] r2;
  logic        excl, lst;

  // intermediates
  logic [31:0] tmp;
  logic [15:0] eps, sig;
  logic [63:0] s, p, s6;
  logic        psat;
  logic [47:0] term;
  logic        term_sat;

  logic [47:0] sum;
  logic        sat_flag;

  ljpe_pkg::alu_req_t req;
  ljpe_pkg::alu_rsp_t rsp;

  ljpe_alu u_alu (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  logic         op_state;
  logic         q_sat;
  logic [63:0]  q_val;
  logic         neg;
  logic [63:0]  mag;
  logic [127:0] tshift;
  logic         t_sat;
  logic [46:0]  t_mag;
  logic [48:0]  sum_wide;
  logic         sum_hi, sum_lo;
  logic [47:0]  sum_next;
  logic         out_free;
  logic         emit;

  assign s_tready = (state == ST_IDLE);
  assign out_free = !m_tvalid || m_tready;
  assign emit     = (state == ST_ACC) && lst && out_free;

  // Q.32 product: floor, saturate above CAPQ.
  assign q_sat = (|rsp.data[127:96]) || (|rsp.data[95:94]);
  assign q_val = q_sat ? ljpe_pkg::CAPQ : rsp.data[95:32];

  assign neg = s6 < p;
  assign mag = neg ? (p - s6) : (s6 - p);

  // Drop the extra fraction bits of the Q.44 term; clamp the magnitude.
  assign tshift = rsp.data >> ljpe_pkg::TERM_SHIFT;
  assign t_sat  = |tshift[127:47];
  assign t_mag  = t_sat ? ljpe_pkg::TERM_MAX : tshift[46:0];

  assign sum_wide = excl ? ({sum[47], sum} - {term[47], term})
                         : ({sum[47], sum} + {term[47], term});
  assign sum_hi   = !sum_wide[48] && sum_wide[47];
  assign sum_lo   = sum_wide[48] && !sum_wide[47];
  assign sum_next = sum_hi ? {1'b0, ljpe_pkg::TERM_MAX}
                  : sum_lo ? {1'b1, 47'b0} : sum_wide[47:0];

  // Operand selection for the shared unit.
  always_comb begin
    op_state = 1'b1;
    req.op   = ljpe_pkg::ALU_MUL;
    req.a    = '0;
    req.b    = '0;
    case (state)
      ST_EPS_MUL: begin
        req.a = {48'b0, ea};
        req.b = {48'b0, eb};
      end
      ST_EPS_SQRT: begin
        req.op = ljpe_pkg::ALU_SQRT;
        req.a  = {32'b0, tmp};
      end
      ST_SIG_MUL: begin
        req.a = {48'b0, sa};
        req.b = {48'b0, sb};
      end
      ST_SIG_SQRT: begin
        req.op = ljpe_pkg::ALU_SQRT;
        req.a  = {32'b0, tmp};
      end
      ST_SQ: begin
        req.a = {48'b0, sig};
        req.b = {48'b0, sig};
      end
      ST_DIV: begin
        req.op = ljpe_pkg::ALU_DIV;
        req.a  = {8'b0, tmp, 24'b0};
        req.b  = {40'b0, r2};
      end
      ST_P1: begin
        req.a = s;
        req.b = s;
      end
      ST_P2: begin
        req.a = p;
        req.b = s;
      end
      ST_P3: begin
        req.a = p;
        req.b = p;
      end
      ST_TERM: begin
        req.a = mag;
        req.b = {47'b0, eps, 1'b0};
      end
      default: begin
        op_state = 1'b0;
      end
    endcase
    req.start = op_state && !pending;
  end

  // Sequencer and control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      pending  <= 1'b0;
      rule     <= ljpe_pkg::RULE_RESET;
      sum      <= '0;
      sat_flag <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_we) begin
        rule <= cfg_wdata;
      end
      // Load a new result, or drop the one just taken.
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (req.start) begin
        pending <= 1'b1;
      end else if (rsp.done) begin
        pending <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            state <= ST_EPS_MUL;
          end
        end
        ST_EPS_MUL: begin
          if (rsp.done) begin
            state <= ST_EPS_SQRT;
          end
        end
        ST_EPS_SQRT: begin
          if (rsp.done) begin
            if (rsp.data[15:0] == 16'd0) begin
              state <= ST_ACC;
            end else if (rule == ljpe_pkg::RULE_GEOMETRIC) begin
              state <= ST_SIG_MUL;
            end else begin
              state <= ST_SQ;
            end
          end
        end
        ST_SIG_MUL: begin
          if (rsp.done) begin
            state <= ST_SIG_SQRT;
          end
        end
        ST_SIG_SQRT: begin
          if (rsp.done) begin
            state <= ST_SQ;
          end
        end
        ST_SQ: begin
          if (rsp.done) begin
            state <= (r2 == 24'd0) ? ST_P1 : ST_DIV;
          end
        end
        ST_DIV: begin
          if (rsp.done) begin
            state <= ST_P1;
          end
        end
        ST_P1: begin
          if (rsp.done) begin
            state <= ST_P2;
          end
        end
        ST_P2: begin
          if (rsp.done) begin
            state <= ST_P3;
          end
        end
        ST_P3: begin
          if (rsp.done) begin
            state <= (psat || q_sat) ? ST_ACC : ST_TERM;
          end
        end
        ST_TERM: begin
          if (rsp.done) begin
            state <= ST_ACC;
          end
        end
        ST_ACC: begin
          if (!lst) begin
            sum      <= sum_next;
            sat_flag <= sat_flag || term_sat || sum_hi || sum_lo;
            state    <= ST_IDLE;
          end else if (out_free) begin
            // emit, then clear the running sum
            sum      <= '0;
            sat_flag <= 1'b0;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Pair payload and intermediates.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          sa       <= s_tdata[15:0];
          sb       <= s_tdata[31:16];
          ea       <= s_tdata[47:32];
          eb       <= s_tdata[63:48];
          r2       <= s_tdata[87:64];
          excl     <= s_tuser;
          lst      <= s_tlast;
          psat     <= 1'b0;
          term     <= '0;
          term_sat <= 1'b0;
        end
      end
      ST_EPS_MUL, ST_SIG_MUL: begin
        if (rsp.done) begin
          tmp <= rsp.data[31:0];
        end
      end
      ST_EPS_SQRT: begin
        if (rsp.done) begin
          eps <= rsp.data[15:0];
          sig <= 16'(({1'b0, sa} + {1'b0, sb}) >> 1);
        end
      end
      ST_SIG_SQRT: begin
        if (rsp.done) begin
          sig <= rsp.data[15:0];
        end
      end
      ST_SQ: begin
        if (rsp.done) begin
          tmp <= rsp.data[31:0];
          if (r2 == 24'd0) begin
            psat <= 1'b1;
            s    <= ljpe_pkg::CAPQ;
          end
        end
      end
      ST_DIV: begin
        if (rsp.done) begin
          s <= rsp.data[63:0];
        end
      end
      ST_P1, ST_P2: begin
        if (rsp.done) begin
          p    <= q_val;
          psat <= psat || q_sat;
        end
      end
      ST_P3: begin
        if (rsp.done) begin
          s6 <= q_val;
          if (psat || q_sat) begin
            term     <= {1'b0, ljpe_pkg::TERM_MAX};
            term_sat <= 1'b1;
          end
        end
      end
      ST_TERM: begin
        if (rsp.done) begin
          term     <= neg ? (48'd0 - {1'b0, t_mag}) : {1'b0, t_mag};
          term_sat <= t_sat;
        end
      end
      ST_ACC: begin
        if (lst && out_free) begin
          m_tdata <= sum_next;
          m_tuser <= sat_flag || term_sat || sum_hi || sum_lo;
        end
      end
      default: begin
        term_sat <= term_sat;
      end
    endcase
  end

endmodule
`default_nettype wire
